[rtl/core/tsc_pkg.sv]
// Shared types and constants for the A/V timestamp corrector.
// No dependencies; every rtl/core file refers to it by scoped names.
package tsc_pkg;

   localparam int TIME_W  = 32;   // raw and reported timestamp width
   localparam int FIX_W   = 63;   // corrected value, never negative
   localparam int CFG_W   = 16;   // width of each control register
   localparam int STEP_W  = CFG_W + 1;
   localparam int CNT_W   = 2;    // audio-since-video counter
   localparam int INDEX_W = 2;

   localparam logic [CNT_W-1:0] CNT_ZERO = CNT_W'(0);
   localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(2);

   localparam logic [FIX_W-1:0] FIX_MAX = {FIX_W{1'b1}};

   // packet kinds
   typedef enum logic [1:0] {
      MODE_VIDEO  = 2'd0,
      MODE_AUDIO  = 2'd1,
      MODE_HEADER = 2'd2,
      MODE_OTHER  = 2'd3
   } mode_type;

   // control register indexes
   typedef enum logic [INDEX_W-1:0] {
      CSR_VIDEO_DELTA_LIMIT  = 2'd0,
      CSR_VIDEO_DEFAULT_STEP = 2'd1,
      CSR_AUDIO_DELTA_LIMIT  = 2'd2,
      CSR_AUDIO_DEFAULT_STEP = 2'd3
   } csr_index_type;

   localparam logic [CFG_W-1:0] RST_VIDEO_DELTA_LIMIT  = CFG_W'(100);
   localparam logic [CFG_W-1:0] RST_VIDEO_DEFAULT_STEP = CFG_W'(40);
   localparam logic [CFG_W-1:0] RST_AUDIO_DELTA_LIMIT  = CFG_W'(100);
   localparam logic [CFG_W-1:0] RST_AUDIO_DEFAULT_STEP = CFG_W'(20);

   typedef struct packed {
      logic [CFG_W-1:0] video_delta_limit;
      logic [CFG_W-1:0] video_default_step;
      logic [CFG_W-1:0] audio_delta_limit;
      logic [CFG_W-1:0] audio_default_step;
   } cfg_type;

   typedef struct packed {
      mode_type          mode;
      logic [TIME_W-1:0] raw_time;
   } item_type;

endpackage

[rtl/core/tsc_csr.sv]
// Control register bank for the timestamp corrector.
// Depends on tsc_pkg.
module tsc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [tsc_pkg::INDEX_W-1:0]  csr_index,
   input  logic [tsc_pkg::CFG_W-1:0]    csr_wr_data,
   output tsc_pkg::cfg_type             cfg
);

   tsc_pkg::cfg_type cfg_ff;
   tsc_pkg::cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (tsc_pkg::csr_index_type'(csr_index))
            tsc_pkg::CSR_VIDEO_DELTA_LIMIT:  cfg_in.video_delta_limit  = csr_wr_data;
            tsc_pkg::CSR_VIDEO_DEFAULT_STEP: cfg_in.video_default_step = csr_wr_data;
            tsc_pkg::CSR_AUDIO_DELTA_LIMIT:  cfg_in.audio_delta_limit  = csr_wr_data;
            tsc_pkg::CSR_AUDIO_DEFAULT_STEP: cfg_in.audio_default_step = csr_wr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.video_delta_limit  <= tsc_pkg::RST_VIDEO_DELTA_LIMIT;
         cfg_ff.video_default_step <= tsc_pkg::RST_VIDEO_DEFAULT_STEP;
         cfg_ff.audio_delta_limit  <= tsc_pkg::RST_AUDIO_DELTA_LIMIT;
         cfg_ff.audio_default_step <= tsc_pkg::RST_AUDIO_DEFAULT_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/tsc_step.sv]
// One correction step: pick the delta or the default step, then add it to
// the base with clamping at zero and saturation at the top. Uses tsc_pkg.
module tsc_step (
   input  logic [tsc_pkg::TIME_W-1:0] raw_time,
   input  logic [tsc_pkg::TIME_W-1:0] base_raw,
   input  logic [tsc_pkg::FIX_W-1:0]  base_fix,
   input  logic [tsc_pkg::CFG_W-1:0]  limit,
   input  logic [tsc_pkg::CFG_W-1:0]  default_step,
   output logic [tsc_pkg::FIX_W-1:0]  fix
);

   localparam int DELTA_W = tsc_pkg::TIME_W + 1;
   localparam int CMP_W   = DELTA_W + 1;
   localparam int SUM_W   = tsc_pkg::FIX_W + 2;

   logic signed [DELTA_W-1:0]        delta;
   logic signed [CMP_W-1:0]          delta_x;
   logic signed [CMP_W-1:0]          lim_x;
   logic                             plausible;
   logic signed [tsc_pkg::STEP_W-1:0] step;
   logic signed [SUM_W-1:0]          sum;

   // signed delta between the two raw timestamps
   assign delta   = $signed({1'b0, raw_time}) - $signed({1'b0, base_raw});
   assign delta_x = CMP_W'(delta);
   assign lim_x   = $signed({{(CMP_W - tsc_pkg::CFG_W){1'b0}}, limit});

   // keep the delta only inside the open window
   assign plausible = (delta_x > -lim_x) && (delta_x < lim_x);
   assign step = plausible ? delta[tsc_pkg::STEP_W-1:0]
                           : $signed({1'b0, default_step});

   // add, clamp negative to zero, saturate on overflow
   assign sum = $signed({2'b00, base_fix}) + SUM_W'(step);

   always_comb begin
      priority if (sum[SUM_W-1]) begin
         fix = '0;
      end else if (sum[SUM_W-2]) begin
         fix = tsc_pkg::FIX_MAX;
      end else begin
         fix = sum[tsc_pkg::FIX_W-1:0];
      end
   end

endmodule

[rtl/core/tsc_core.sv]
// Stream state of the timestamp corrector and the per-packet update.
// Depends on tsc_pkg and tsc_step.
module tsc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  tsc_pkg::item_type          item,
   input  tsc_pkg::cfg_type           cfg,
   output logic [tsc_pkg::TIME_W-1:0] fixed_time
);

   localparam int GAP_W = tsc_pkg::TIME_W + 2;

   logic [tsc_pkg::TIME_W-1:0] video_last_raw_ff, video_last_raw_in;
   logic [tsc_pkg::FIX_W-1:0]  video_last_fixed_ff, video_last_fixed_in;
   logic                       video_seen_ff, video_seen_in;
   logic [tsc_pkg::TIME_W-1:0] audio_last_raw_ff, audio_last_raw_in;
   logic [tsc_pkg::FIX_W-1:0]  audio_last_fixed_ff, audio_last_fixed_in;
   logic                       audio_seen_ff, audio_seen_in;
   logic [tsc_pkg::CNT_W-1:0]  audio_since_video_ff, audio_since_video_in;

   logic [tsc_pkg::FIX_W-1:0]  raw_as_fix;
   logic [tsc_pkg::TIME_W-1:0] v_base_raw;
   logic [tsc_pkg::FIX_W-1:0]  v_base_fix;
   logic [tsc_pkg::FIX_W-1:0]  v_fix;
   logic [tsc_pkg::CFG_W-1:0]  a_limit;
   logic [tsc_pkg::CFG_W-1:0]  a_default;
   logic [tsc_pkg::FIX_W-1:0]  a_fix;
   logic [tsc_pkg::TIME_W-1:0] gap;
   logic signed [GAP_W-1:0]    gap_x;
   logic signed [GAP_W-1:0]    vlim_x;
   logic                       realign;
   logic [tsc_pkg::FIX_W-1:0]  result;

   assign raw_as_fix = {{(tsc_pkg::FIX_W - tsc_pkg::TIME_W){1'b0}}, item.raw_time};

   // video-based step: first video starts at its own raw time
   assign v_base_raw = video_seen_ff ? video_last_raw_ff : item.raw_time;
   assign v_base_fix = video_seen_ff ? video_last_fixed_ff : raw_as_fix;

   tsc_step u_video_step (
      .raw_time     (item.raw_time),
      .base_raw     (v_base_raw),
      .base_fix     (v_base_fix),
      .limit        (cfg.video_delta_limit),
      .default_step (cfg.video_default_step),
      .fix          (v_fix)
   );

   // audio-based step: video realigned to audio uses the video window
   assign a_limit   = (item.mode == tsc_pkg::MODE_VIDEO) ? cfg.video_delta_limit
                                                         : cfg.audio_delta_limit;
   assign a_default = (item.mode == tsc_pkg::MODE_VIDEO) ? cfg.video_default_step
                                                         : cfg.audio_default_step;

   tsc_step u_audio_step (
      .raw_time     (item.raw_time),
      .base_raw     (audio_last_raw_ff),
      .base_fix     (audio_last_fixed_ff),
      .limit        (a_limit),
      .default_step (a_default),
      .fix          (a_fix)
   );

   // first video far from the last audio snaps to the audio timeline
   assign gap     = audio_last_raw_ff - item.raw_time;
   assign gap_x   = GAP_W'($signed(gap));
   assign vlim_x  = $signed({{(GAP_W - tsc_pkg::CFG_W){1'b0}}, cfg.video_delta_limit});
   assign realign = !video_seen_ff && audio_seen_ff
                    && !((gap_x > -vlim_x) && (gap_x < vlim_x));

   // next state and result
   always_comb begin
      video_last_raw_in    = video_last_raw_ff;
      video_last_fixed_in  = video_last_fixed_ff;
      video_seen_in        = video_seen_ff;
      audio_last_raw_in    = audio_last_raw_ff;
      audio_last_fixed_in  = audio_last_fixed_ff;
      audio_seen_in        = audio_seen_ff;
      audio_since_video_in = audio_since_video_ff;
      result               = '0;
      unique case (item.mode)
         tsc_pkg::MODE_VIDEO: begin
            result               = realign ? a_fix : v_fix;
            video_last_raw_in    = item.raw_time;
            video_last_fixed_in  = result;
            video_seen_in        = 1'b1;
            audio_since_video_in = tsc_pkg::CNT_ZERO;
         end
         tsc_pkg::MODE_AUDIO: begin
            audio_since_video_in = (audio_since_video_ff == tsc_pkg::CNT_SAT)
                                   ? tsc_pkg::CNT_SAT
                                   : audio_since_video_ff + tsc_pkg::CNT_W'(1);
            priority if (audio_since_video_ff != tsc_pkg::CNT_ZERO && audio_seen_ff) begin
               result = a_fix;
            end else if (audio_since_video_ff != tsc_pkg::CNT_ZERO || !video_seen_ff) begin
               result = raw_as_fix;
            end else begin
               result = v_fix;
            end
            audio_last_raw_in   = item.raw_time;
            audio_last_fixed_in = result;
            audio_seen_in       = 1'b1;
         end
         tsc_pkg::MODE_HEADER, tsc_pkg::MODE_OTHER: begin
            result = '0;
         end
         default: result = '0;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         video_seen_ff        <= 1'b0;
         audio_seen_ff        <= 1'b0;
         audio_since_video_ff <= tsc_pkg::CNT_ZERO;
         video_last_raw_ff    <= '0;
         video_last_fixed_ff  <= '0;
         audio_last_raw_ff    <= '0;
         audio_last_fixed_ff  <= '0;
      end else if (fire) begin
         video_seen_ff        <= video_seen_in;
         audio_seen_ff        <= audio_seen_in;
         audio_since_video_ff <= audio_since_video_in;
         video_last_raw_ff    <= video_last_raw_in;
         video_last_fixed_ff  <= video_last_fixed_in;
         audio_last_raw_ff    <= audio_last_raw_in;
         audio_last_fixed_ff  <= audio_last_fixed_in;
      end
   end

   assign fixed_time = result[tsc_pkg::TIME_W-1:0];

endmodule

[rtl/core/av_timestamp_corrector_unit.sv]
// Top level of the A/V timestamp corrector: input and result registers
// around the stream update. Depends on tsc_pkg, tsc_csr and tsc_core.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_mode, req_raw_time
//   rsp      out        rsp_valid / rsp_ready  rsp_fixed_time
//   csr      in         csr_wr_en              csr_index, csr_wr_data
//
// One beat per cycle sustained while rsp_ready holds; an accepted packet waits in
// the input register and its result is loaded into the result register when free.
// The update is a single pass of subtract, window compare and one wide add.
// Synchronous active-high reset clears both stage valids and stream state.
// A stalled result holds; the input register keeps accepting until both
// stages are full.
module av_timestamp_corrector_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_mode,
   input  logic [tsc_pkg::TIME_W-1:0]   req_raw_time,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tsc_pkg::TIME_W-1:0]   rsp_fixed_time,
   input  logic                         csr_wr_en,
   input  logic [tsc_pkg::INDEX_W-1:0]  csr_index,
   input  logic [tsc_pkg::CFG_W-1:0]    csr_wr_data
);

   tsc_pkg::cfg_type            cfg;
   tsc_pkg::item_type           item_ff, item_in;
   logic                        item_valid_ff, item_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tsc_pkg::TIME_W-1:0]  rsp_time_ff, rsp_time_in;
   logic [tsc_pkg::TIME_W-1:0]  core_time;
   logic                        advance;
   logic                        req_fire;

   tsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // move the held beat into the result register when it is free
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   tsc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (item_ff),
      .cfg        (cfg),
      .fixed_time (core_time)
   );

   // input register
   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_fire) begin
         item_in.mode     = tsc_pkg::mode_type'(req_mode);
         item_in.raw_time = req_raw_time;
         item_valid_in    = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_time_in  = rsp_time_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_time_in  = core_time;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fixed_time = rsp_time_ff;

`ifndef ASSERT_OFF
   // header and other packets report zero
   assert property (@(posedge clock) disable iff (reset)
      advance && (item_ff.mode == tsc_pkg::MODE_HEADER || item_ff.mode == tsc_pkg::MODE_OTHER)
      |=> rsp_fixed_time == '0)
      else $error("header packet gave a nonzero timestamp");

   // no new beat while both stages are full and the result is stalled
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input accepted with both stages full");

   // a beat moved forward is offered on the result side next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced beat missing from result register");
`endif

endmodule

[dv/tb_ts_scoreboard_pkg.sv]
// Scoreboard for the A/V timestamp corrector: predicts each corrected timestamp
// and matches result beats against it in order.
// Depends on tsc_pkg for the packet kinds, register indexes and reset values.
`timescale 1ns / 1ps

package tb_ts_scoreboard_pkg;
   import tsc_pkg::*;

   class ts_scoreboard;
      // register copies
      bit [15:0]  video_limit;
      bit [15:0]  video_step;
      bit [15:0]  audio_limit;
      bit [15:0]  audio_step;
      // stream state
      longint     video_raw;
      longint     video_fixed;
      bit         video_seen;
      longint     audio_raw;
      longint     audio_fixed;
      bit         audio_seen;
      bit [1:0]   audio_run;
      // corrected timestamps still to come out, oldest first
      bit [31:0]  pending_fixed[$];
      int         errors;

      function new();
         errors = 0;
         video_limit = RST_VIDEO_DELTA_LIMIT;
         video_step  = RST_VIDEO_DEFAULT_STEP;
         audio_limit = RST_AUDIO_DELTA_LIMIT;
         audio_step  = RST_AUDIO_DEFAULT_STEP;
         video_raw   = 0;
         video_fixed = 0;
         video_seen  = 1'b0;
         audio_raw   = 0;
         audio_fixed = 0;
         audio_seen  = 1'b0;
         audio_run   = 2'd0;
      endfunction

      function void write_csr(csr_index_type idx, bit [15:0] value);
         case (idx)
            CSR_VIDEO_DELTA_LIMIT:  video_limit = value;
            CSR_VIDEO_DEFAULT_STEP: video_step  = value;
            CSR_AUDIO_DELTA_LIMIT:  audio_limit = value;
            CSR_AUDIO_DEFAULT_STEP: audio_step  = value;
            default: ;
         endcase
      endfunction

      // keep a delta inside the open window, otherwise fall back to the default step
      function longint window_step(longint delta, longint lim, longint fallback);
         if (delta > -lim && delta < lim) return delta;
         return fallback;
      endfunction

      // add with saturation at the top and a floor of zero
      function longint advance(longint base, longint stepv);
         if (stepv > 0 && base > 64'sh7FFF_FFFF_FFFF_FFFF - stepv)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
         base = base + stepv;
         return (base < 0) ? 0 : base;
      endfunction

      function longint video_packet(longint t);
         bit [31:0] w;
         int        d32;
         longint    d;
         longint    lim;
         longint    stepv;
         audio_run = 2'd0;
         if (!video_seen) begin
            video_raw   = t;
            video_fixed = t;
            video_seen  = 1'b1;
            // first video far from audio: realign video to audio
            if (audio_seen) begin
               w   = audio_raw[31:0] - t[31:0];
               d32 = int'(w);
               d   = d32;
               lim = video_limit;
               if (d <= -lim || d >= lim) begin
                  video_raw   = audio_raw;
                  video_fixed = audio_fixed;
               end
            end
         end
         stepv       = window_step(t - video_raw, video_limit, video_step);
         video_raw   = t;
         video_fixed = advance(video_fixed, stepv);
         return video_fixed;
      endfunction

      function longint audio_packet(longint t);
         longint stepv;
         if (audio_run < 2'd2) audio_run++;
         if (audio_run > 2'd1 || !video_seen) begin
            // follow the audio stream
            if (audio_run > 2'd1 && audio_seen) begin
               stepv       = window_step(t - audio_raw, audio_limit, audio_step);
               audio_raw   = t;
               audio_fixed = advance(audio_fixed, stepv);
               return audio_fixed;
            end
            // nothing to follow: start at the raw time
            audio_raw   = t;
            audio_fixed = t;
            audio_seen  = 1'b1;
            return t;
         end
         // first audio after video: align to video
         stepv       = window_step(t - video_raw, video_limit, video_step);
         audio_raw   = t;
         audio_fixed = advance(video_fixed, stepv);
         audio_seen  = 1'b1;
         return audio_fixed;
      endfunction

      // an accepted packet beat: queue its corrected timestamp
      function void note_packet(mode_type m, bit [31:0] raw);
         longint t;
         longint r;
         t = {32'd0, raw};
         r = 0;
         case (m)
            MODE_VIDEO: r = video_packet(t);
            MODE_AUDIO: r = audio_packet(t);
            default:    r = 0;
         endcase
         pending_fixed.push_back(r[31:0]);
      endfunction

      // an accepted result beat: match against the oldest prediction
      function void check_fixed_time(bit [31:0] got);
         bit [31:0] want;
         if (pending_fixed.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual fixed_time=%h",
                     $time, got);
            errors++;
            return;
         end
         want = pending_fixed.pop_front();
         if (want != got) begin
            $display("%0t: fixed_time mismatch, expected %h, actual %h", $time, want, got);
            errors++;
         end
      endfunction

      function int pending();
         return pending_fixed.size();
      endfunction
   endclass

endpackage

[dv/tb_top.sv]
// Top of the A/V timestamp corrector testbench: clock, reset, packet and
// result drivers, register writes and the phased stimulus.
// Depends on tsc_pkg, tb_ts_scoreboard_pkg and av_timestamp_corrector_unit.
`timescale 1ns / 1ps

module tb_top;
   import tsc_pkg::*;
   import tb_ts_scoreboard_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_HEADER;
   logic [31:0] req_raw_time = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_fixed_time;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_VIDEO_DELTA_LIMIT;
   logic [15:0] csr_wr_data = 16'd0;

   ts_scoreboard sb;
   bit           no_idle = 1'b0;
   bit [31:0]    cursor = 32'd0;

   av_timestamp_corrector_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_raw_time   (req_raw_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_fixed_time (rsp_fixed_time),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, none during a busy stretch
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // drive one packet beat, hold until accepted, then maybe pause
   task automatic send_packet(mode_type m, bit [31:0] raw);
      int gap;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_raw_time <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_packet(m, raw);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, bit [15:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.write_csr(idx, value);
   endtask

   // drain every result, then rewrite all four registers
   task automatic configure(bit [15:0] v_lim, bit [15:0] v_step,
                            bit [15:0] a_lim, bit [15:0] a_step);
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_csr(CSR_VIDEO_DELTA_LIMIT, v_lim);
      write_csr(CSR_VIDEO_DEFAULT_STEP, v_step);
      write_csr(CSR_AUDIO_DELTA_LIMIT, a_lim);
      write_csr(CSR_AUDIO_DEFAULT_STEP, a_step);
   endtask

   // random packets whose times mostly step near the current windows
   task automatic run_random(int count);
      int        i;
      int        r;
      int        span;
      mode_type  m;
      bit [31:0] raw;
      span = ((sb.video_limit > sb.audio_limit) ? sb.video_limit : sb.audio_limit) + 8;
      for (i = 0; i < count; i++) begin
         no_idle = (i < 40);
         r = $urandom_range(0, 99);
         if (r < 40)      m = MODE_VIDEO;
         else if (r < 85) m = MODE_AUDIO;
         else if (r < 93) m = MODE_HEADER;
         else             m = MODE_OTHER;
         r = $urandom_range(0, 19);
         if (r == 0) begin
            raw = $urandom;
            cursor = raw;
         end else if (r == 1) begin
            raw = cursor + $urandom_range(0, 1 << 20);
            cursor = raw;
         end else if (r == 2) begin
            // lag behind without moving the cursor
            raw = cursor - $urandom_range(0, 4 * span);
         end else if (r == 3) begin
            raw = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            cursor = raw;
         end else begin
            raw = cursor + $urandom_range(0, 2 * span) - span;
            cursor = raw;
         end
         send_packet(m, raw);
      end
      no_idle = 1'b0;
   endtask

   // result side: ready runs with stalls of random length
   initial begin
      int stall;
      int run_len;
      forever begin
         stall   = pick_gap();
         run_len = $urandom_range(1, 20);
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat (run_len - 1) @(negedge clock);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   // check each result beat at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_fixed_time(rsp_fixed_time);
   end

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: header kinds, first audio, clamp, window edges,
      // realign of first video, audio alignment to video, extremes
      send_packet(MODE_HEADER, 32'hFFFF_FFFF);
      send_packet(MODE_OTHER, 32'd0);
      send_packet(MODE_AUDIO, 32'd30);
      send_packet(MODE_AUDIO, 32'd0);
      send_packet(MODE_AUDIO, 32'd99);
      send_packet(MODE_AUDIO, 32'd199);
      send_packet(MODE_VIDEO, 32'd70000);
      send_packet(MODE_AUDIO, 32'd70010);
      send_packet(MODE_AUDIO, 32'd70020);
      send_packet(MODE_AUDIO, 32'd70030);
      send_packet(MODE_VIDEO, 32'd69901);
      send_packet(MODE_VIDEO, 32'd69801);
      send_packet(MODE_HEADER, 32'd12345);
      send_packet(MODE_VIDEO, 32'd0);
      send_packet(MODE_VIDEO, 32'hFFFF_FFFF);
      send_packet(MODE_AUDIO, 32'hFFFF_FFFE);
      send_packet(MODE_AUDIO, 32'd0);
      send_packet(MODE_OTHER, 32'hFFFF_FFFF);
      send_packet(MODE_AUDIO, 32'hAAAA_AAAA);
      send_packet(MODE_VIDEO, 32'hAAAA_AAAA);
      send_packet(MODE_VIDEO, 32'h5555_5555);
      send_packet(MODE_AUDIO, 32'h5555_5555);

      // zero windows: every step falls back to the default
      configure(16'd0, 16'd0, 16'd0, 16'd0);
      run_random(200);
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(200);
      configure(16'd1, 16'd0, 16'd1, 16'hFFFF);
      run_random(200);
      configure($urandom_range(1, 2000), $urandom_range(0, 65535),
                $urandom_range(1, 2000), $urandom_range(0, 65535));
      run_random(200);
      configure(RST_VIDEO_DELTA_LIMIT, RST_VIDEO_DEFAULT_STEP,
                RST_AUDIO_DELTA_LIMIT, RST_AUDIO_DEFAULT_STEP);
      run_random(200);

      // drain and let the pipeline settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #10000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
